>>> rtl/bsr_pkg.sv
// ----------------------------------------------------------------------------
// bsr_pkg: shared types and constants for the block-local scratch renamer
// Sizes, register codes, the lookup result type and small helper functions.
// ----------------------------------------------------------------------------
package bsr_pkg;

    // sizes
    localparam int NUM_REGS      = 256;
    localparam int NUM_SLOTS     = 6;
    localparam int MAX_OPERANDS  = 3;
    localparam int OP_FIELDS     = 3;
    localparam int REG_W         = 16;
    localparam int IDX_W         = $clog2(NUM_REGS);
    localparam int SLOT_W        = $clog2(NUM_SLOTS);
    localparam int CFG_W         = 8;
    localparam int CFG_IDX_W     = 1;
    localparam int CNT_W         = 2;

    // config register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_SCRATCH_BASE = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_FLOOR   = CFG_IDX_W'(1);

    // config reset values
    localparam logic [CFG_W-1:0] SCRATCH_BASE_RST = 8'd10;
    localparam logic [CFG_W-1:0] TEMP_FLOOR_RST   = 8'd16;

    typedef logic [REG_W-1:0] t_reg;
    typedef logic [NUM_SLOTS-1:0][IDX_W-1:0] t_owner_vec;

    // result of a match against the slot owners
    typedef struct packed {
        logic              hit;
        logic [SLOT_W-1:0] slot;
    } t_lookup;

    // registers that are never handed a scratch slot
    function automatic logic is_reserved(input t_reg r);
        return r inside {16'd0, 16'd1, 16'd2, 16'd4, 16'd5, 16'd8, 16'd9};
    endfunction

    // register number of a scratch slot
    function automatic t_reg slot_reg(input logic [CFG_W-1:0] base,
                                      input logic [SLOT_W-1:0] slot);
        return t_reg'(base) + t_reg'(slot);
    endfunction

endpackage

>>> rtl/bsr_lookup.sv
// ----------------------------------------------------------------------------
// bsr_lookup: rename table lookup
// Matches one register number against the owner of every used scratch slot.
// Each register owns at most one slot, so the match is one-hot.
// ----------------------------------------------------------------------------
module bsr_lookup (
    input  bsr_pkg::t_reg                            i_reg,
    input  bsr_pkg::t_owner_vec                      i_owner,
    input  logic [bsr_pkg::NUM_SLOTS-1:0]            i_used,
    output bsr_pkg::t_lookup                         o_result
);

    // parallel compare against all slot owners
    always_comb begin
        logic in_range;
        in_range = (i_reg < bsr_pkg::t_reg'(bsr_pkg::NUM_REGS));
        o_result = '0;
        for (int s = 0; s < bsr_pkg::NUM_SLOTS; s++) begin
            if (in_range && i_used[s] &&
                i_reg[bsr_pkg::IDX_W-1:0] == i_owner[s]) begin
                o_result.hit  = 1'b1;
                o_result.slot = o_result.slot | bsr_pkg::SLOT_W'(s);
            end
        end
    end

endmodule

>>> rtl/block_local_scratch_renamer.sv
// ----------------------------------------------------------------------------
// block_local_scratch_renamer: scratch register renamer
// Rewrites temporaries to a small scratch set, cleared at every barrier.
// ----------------------------------------------------------------------------
// One instruction is taken on any cycle that i_start is high; o_busy is never
// raised, so a new instruction may follow in every cycle. The result appears
// with o_valid two cycles after the transfer (input register, then result
// register) and stays on the ports for that one cycle only: the receiver
// cannot stall it and must take it then. The rename table is held as one
// owner register number per scratch slot plus a used mark, so lookup is a
// six-way compare and a barrier clears everything in one cycle. Configuration
// writes (scratch base, temporary floor) take effect at once and belong only
// in idle periods.
module block_local_scratch_renamer (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // configuration
    input  logic                              i_cfg_we,
    input  logic [bsr_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [bsr_pkg::CFG_W-1:0]         i_cfg_data,
    // command
    input  logic                              i_start,
    output logic                              o_busy,
    input  logic                              i_action,
    input  logic [bsr_pkg::CNT_W-1:0]         i_op_count,
    input  logic                              i_op0_is_reg,
    input  logic [bsr_pkg::REG_W-1:0]         i_op0_reg,
    input  logic                              i_op1_is_reg,
    input  logic [bsr_pkg::REG_W-1:0]         i_op1_reg,
    input  logic                              i_op2_is_reg,
    input  logic [bsr_pkg::REG_W-1:0]         i_op2_reg,
    // result
    output logic                              o_valid,
    output logic [bsr_pkg::REG_W-1:0]         o_out_op0_reg,
    output logic [bsr_pkg::REG_W-1:0]         o_out_op1_reg,
    output logic [bsr_pkg::REG_W-1:0]         o_out_op2_reg,
    output logic                              o_dst_allocated
);

    localparam int NOPS = bsr_pkg::OP_FIELDS;

    // config registers
    logic [bsr_pkg::CFG_W-1:0] r_scratch_base;
    logic [bsr_pkg::CFG_W-1:0] r_temp_floor;

    // input register
    logic                          r_in_vld;
    logic                          r_action;
    logic [bsr_pkg::CNT_W-1:0]     r_count;
    logic [NOPS-1:0]               r_is_reg;
    bsr_pkg::t_reg [NOPS-1:0]      r_reg;

    // rename state
    logic [bsr_pkg::NUM_SLOTS-1:0]     r_used;
    logic [bsr_pkg::NUM_SLOTS-1:0]     n_used;
    bsr_pkg::t_owner_vec               r_owner;
    bsr_pkg::t_owner_vec               n_owner;

    // result register
    logic                          r_out_vld;
    bsr_pkg::t_reg [NOPS-1:0]      r_out_reg;
    bsr_pkg::t_reg [NOPS-1:0]      n_out_reg;
    logic                          r_alloc;
    logic                          n_alloc;

    // lookups
    bsr_pkg::t_lookup [NOPS-1:0]   w_lk;
    bsr_pkg::t_lookup              w_lk_dst;
    bsr_pkg::t_reg [NOPS-1:0]      w_ren;
    logic [NOPS-1:0]               w_op_vld;

    assign o_busy = 1'b0;

    // config writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scratch_base <= bsr_pkg::SCRATCH_BASE_RST;
            r_temp_floor   <= bsr_pkg::TEMP_FLOOR_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                bsr_pkg::CFG_SCRATCH_BASE: r_scratch_base <= i_cfg_data;
                bsr_pkg::CFG_TEMP_FLOOR:   r_temp_floor   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // input register: capture on transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld <= 1'b0;
        end else begin
            r_in_vld <= i_start && !o_busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start && !o_busy) begin
            r_action <= i_action;
            r_count  <= i_op_count;
            r_is_reg <= {i_op2_is_reg, i_op1_is_reg, i_op0_is_reg};
            r_reg[0] <= i_op0_reg;
            r_reg[1] <= i_op1_reg;
            r_reg[2] <= i_op2_reg;
        end
    end

    // first pass: rename every valid register operand that has a mapping
    for (genvar g = 0; g < NOPS; g++) begin : g_op
        bsr_lookup u_lookup (
            .i_reg    (r_reg[g]),
            .i_owner  (r_owner),
            .i_used   (r_used),
            .o_result (w_lk[g])
        );

        assign w_op_vld[g] = (bsr_pkg::CNT_W'(g) < r_count) &&
                             (g < bsr_pkg::MAX_OPERANDS) && r_is_reg[g];
        assign w_ren[g]    = (w_op_vld[g] && w_lk[g].hit) ?
                             bsr_pkg::slot_reg(r_scratch_base, w_lk[g].slot) :
                             r_reg[g];
    end

    // second check on the (possibly renamed) destination
    bsr_lookup u_lookup_dst (
        .i_reg    (w_ren[0]),
        .i_owner  (r_owner),
        .i_used   (r_used),
        .o_result (w_lk_dst)
    );

    // destination mapping and slot allocation
    always_comb begin
        logic                      dst_ok;
        logic                      free_hit;
        logic [bsr_pkg::SLOT_W-1:0] free_slot;

        free_hit  = 1'b0;
        free_slot = '0;
        // lowest free slot
        for (int s = bsr_pkg::NUM_SLOTS - 1; s >= 0; s--) begin
            if (!r_used[s]) begin
                free_hit  = 1'b1;
                free_slot = bsr_pkg::SLOT_W'(s);
            end
        end

        dst_ok = w_op_vld[0] &&
                 (w_ren[0] < bsr_pkg::t_reg'(bsr_pkg::NUM_REGS)) &&
                 !bsr_pkg::is_reserved(w_ren[0]) &&
                 (w_ren[0] >= bsr_pkg::t_reg'(r_temp_floor));

        n_used    = r_used;
        n_owner   = r_owner;
        n_alloc   = 1'b0;
        n_out_reg = w_ren;

        if (r_action) begin
            // barrier: pass through, drop all mappings
            n_out_reg = r_reg;
            n_used    = '0;
        end else if (dst_ok) begin
            if (w_lk_dst.hit) begin
                n_out_reg[0] = bsr_pkg::slot_reg(r_scratch_base, w_lk_dst.slot);
            end else if (free_hit) begin
                n_out_reg[0]       = bsr_pkg::slot_reg(r_scratch_base, free_slot);
                n_used[free_slot]  = 1'b1;
                n_owner[free_slot] = w_ren[0][bsr_pkg::IDX_W-1:0];
                n_alloc            = 1'b1;
            end
        end
    end

    // state update, only for an item in the input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (r_in_vld) begin
            r_used <= n_used;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_vld) begin
            r_owner <= n_owner;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else begin
            r_out_vld <= r_in_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_in_vld) begin
            r_out_reg <= n_out_reg;
            r_alloc   <= n_alloc;
        end
    end

    assign o_valid         = r_out_vld;
    assign o_out_op0_reg   = r_out_reg[0];
    assign o_out_op1_reg   = r_out_reg[1];
    assign o_out_op2_reg   = r_out_reg[2];
    assign o_dst_allocated = r_alloc;

endmodule
